// ----- hdl/tfb_pkg.sv -----
// shared types, widths and helper functions of the tiled fill blit generator
// no dependencies; imported by every module of the block
`default_nettype none

package tfb_pkg;

    // field widths
    localparam int COORD_W   = 16;             // signed coordinates on the input side
    localparam int SIZE_W    = 15;             // unsigned tile and area sizes
    localparam int OUT_W     = COORD_W + 1;    // signed coordinates on the output side
    localparam int WORK_W    = COORD_W + 2;    // internal signed walk arithmetic
    localparam int FLIP_W    = 2;

    // tile limit per fill command
    localparam int MAX_TILES = 64;
    localparam int CNT_W     = $clog2(MAX_TILES + 1);

    // serial remainder unit
    localparam int DIV_STEPS = COORD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIVX = 5'b00010,
        ST_DIVY = 5'b00100,
        ST_PREP = 5'b01000,
        ST_EMIT = 5'b10000
    } t_state;

    // zero-extend a size into the walk width
    function automatic logic signed [WORK_W-1:0] ext_size(input logic [SIZE_W-1:0] v);
        ext_size = $signed({{(WORK_W - SIZE_W){1'b0}}, v});
    endfunction

    // sign-extend a coordinate into the walk width
    function automatic logic signed [WORK_W-1:0] ext_coord(input logic signed [COORD_W-1:0] v);
        ext_coord = {{(WORK_W - COORD_W){v[COORD_W-1]}}, v};
    endfunction

    // magnitude of a signed coordinate; the most negative value fits unsigned
    function automatic logic [COORD_W-1:0] coord_mag(input logic signed [COORD_W-1:0] v);
        coord_mag = v[COORD_W-1] ? COORD_W'(-v) : COORD_W'(v);
    endfunction

    // first grid position in (-size, 0] from |offset| mod size and the offset sign
    function automatic logic signed [WORK_W-1:0] wrap_start(
        input logic              neg,
        input logic [SIZE_W-1:0] rem,
        input logic [SIZE_W-1:0] size
    );
        if (rem == '0) begin
            wrap_start = '0;
        end else if (neg) begin
            wrap_start = -ext_size(rem);
        end else begin
            wrap_start = ext_size(rem) - ext_size(size);
        end
    endfunction

endpackage

`default_nettype wire

// ----- hdl/tfb_div.sv -----
// shared serial remainder unit: one restoring step per cycle
// depends on tfb_pkg
`default_nettype none

module tfb_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [tfb_pkg::COORD_W-1:0] i_dividend,
    input  wire logic [tfb_pkg::SIZE_W-1:0]  i_divisor,
    output logic                            o_done,
    output logic [tfb_pkg::SIZE_W-1:0]       o_rem
);
    import tfb_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [COORD_W-1:0]   r_dvd;
    logic [SIZE_W-1:0]    r_dvs;
    logic [SIZE_W-1:0]    r_rem;
    logic [SIZE_W:0]      trial;
    logic [SIZE_W-1:0]    n_rem;

    // one restoring step: bring down the next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_dvd[COORD_W-1]};
        if (trial >= {1'b0, r_dvs}) begin
            n_rem = SIZE_W'(trial - {1'b0, r_dvs});
        end else begin
            n_rem = trial[SIZE_W-1:0];
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operands and partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[COORD_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ----- hdl/tfb_clip.sv -----
// clips one tile against the area along one axis and mirrors the source offset
// depends on tfb_pkg
`default_nettype none

module tfb_clip (
    input  wire logic signed [tfb_pkg::WORK_W-1:0]  i_pos,     // tile start in area space
    input  wire logic signed [tfb_pkg::WORK_W-1:0]  i_pos_end, // tile start plus tile size
    input  wire logic [tfb_pkg::SIZE_W-1:0]         i_limit,   // area size
    input  wire logic signed [tfb_pkg::COORD_W-1:0] i_src_org, // tile origin in texture
    input  wire logic signed [tfb_pkg::COORD_W-1:0] i_dst_org, // area origin on target
    input  wire logic                               i_mirror,
    output logic signed [tfb_pkg::OUT_W-1:0]        o_src,
    output logic signed [tfb_pkg::OUT_W-1:0]        o_dst,
    output logic [tfb_pkg::SIZE_W-1:0]              o_len
);
    import tfb_pkg::*;

    logic signed [WORK_W-1:0] lim;
    logic signed [WORK_W-1:0] over;
    logic signed [WORK_W-1:0] clip_lo;
    logic signed [WORK_W-1:0] clip_hi;
    logic signed [WORK_W-1:0] lead;
    logic signed [WORK_W-1:0] trail;
    logic signed [WORK_W-1:0] src_off;
    logic signed [WORK_W-1:0] len;
    logic signed [WORK_W-1:0] src;
    logic signed [WORK_W-1:0] dst;

    // clip window and the parts cut off at each end
    always_comb begin
        lim     = ext_size(i_limit);
        over    = i_pos_end - lim;
        lead    = i_pos[WORK_W-1] ? -i_pos : '0;
        clip_lo = i_pos[WORK_W-1] ? '0 : i_pos;
        trail   = (over > 0) ? over : '0;
        clip_hi = (over > 0) ? lim : i_pos_end;
        len     = clip_hi - clip_lo;
        // mirrored parts are taken from the far end of the tile
        src_off = i_mirror ? trail : lead;
        src     = ext_coord(i_src_org) + src_off;
        dst     = ext_coord(i_dst_org) + clip_lo;
    end

    assign o_len = len[SIZE_W-1:0];
    assign o_src = src[OUT_W-1:0];
    assign o_dst = dst[OUT_W-1:0];

endmodule

`default_nettype wire

// ----- hdl/tiled_fill_blit_generator.sv -----
// tiled fill blit generator, depends on tfb_pkg, tfb_div and tfb_clip: two serial remainders
// wrap the scroll offset, then the tile grid is walked with one clipped blit word per cycle
// while the output is not stalled. a command passes through the x and y remainders on the shared
// divider, the setup state and the output word register before its first blit word is valid
// it emits at most MAX_TILES words, no new command is taken until it is done, and a command
// with a zero tile size is accepted and emits nothing. reset: synchronous i_rst_n, idle, no word pending
`default_nettype none

module tiled_fill_blit_generator (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // command channel
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic signed [tfb_pkg::COORD_W-1:0] i_src_left,
    input  wire logic signed [tfb_pkg::COORD_W-1:0] i_src_top,
    input  wire logic [tfb_pkg::SIZE_W-1:0]         i_tile_width,
    input  wire logic [tfb_pkg::SIZE_W-1:0]         i_tile_height,
    input  wire logic signed [tfb_pkg::COORD_W-1:0] i_area_left,
    input  wire logic signed [tfb_pkg::COORD_W-1:0] i_area_top,
    input  wire logic [tfb_pkg::SIZE_W-1:0]         i_area_width,
    input  wire logic [tfb_pkg::SIZE_W-1:0]         i_area_height,
    input  wire logic signed [tfb_pkg::COORD_W-1:0] i_scroll_x,
    input  wire logic signed [tfb_pkg::COORD_W-1:0] i_scroll_y,
    input  wire logic                               i_mirror_h,
    input  wire logic                               i_mirror_v,
    // blit channel
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic signed [tfb_pkg::OUT_W-1:0]        o_blit_src_x,
    output logic signed [tfb_pkg::OUT_W-1:0]        o_blit_src_y,
    output logic [tfb_pkg::SIZE_W-1:0]              o_blit_width,
    output logic [tfb_pkg::SIZE_W-1:0]              o_blit_height,
    output logic signed [tfb_pkg::OUT_W-1:0]        o_blit_dst_x,
    output logic signed [tfb_pkg::OUT_W-1:0]        o_blit_dst_y,
    output logic [tfb_pkg::FLIP_W-1:0]              o_blit_flip,
    output logic                                    o_last_blit,
    output logic                                    o_truncated
);
    import tfb_pkg::*;

    t_state r_state;
    t_state n_state;

    // latched command
    logic signed [COORD_W-1:0] r_sl;
    logic signed [COORD_W-1:0] r_st;
    logic [SIZE_W-1:0]         r_tw;
    logic [SIZE_W-1:0]         r_th;
    logic signed [COORD_W-1:0] r_al;
    logic signed [COORD_W-1:0] r_at;
    logic [SIZE_W-1:0]         r_aw;
    logic [SIZE_W-1:0]         r_ah;
    logic signed [COORD_W-1:0] r_scy;
    logic                      r_scx_neg;
    logic                      r_mh;
    logic                      r_mv;

    // walk cursors
    logic signed [WORK_W-1:0]  r_fx;
    logic signed [WORK_W-1:0]  r_fxe;
    logic signed [WORK_W-1:0]  r_x;
    logic signed [WORK_W-1:0]  r_xe;
    logic signed [WORK_W-1:0]  r_y;
    logic signed [WORK_W-1:0]  r_ye;
    logic [CNT_W-1:0]          r_cnt;

    // output word register
    logic                      r_out_valid;
    logic signed [OUT_W-1:0]   r_src_x;
    logic signed [OUT_W-1:0]   r_src_y;
    logic [SIZE_W-1:0]         r_width;
    logic [SIZE_W-1:0]         r_height;
    logic signed [OUT_W-1:0]   r_dst_x;
    logic signed [OUT_W-1:0]   r_dst_y;
    logic [FLIP_W-1:0]         r_flip;
    logic                      r_last;
    logic                      r_trunc;

    logic                      accept;
    logic                      size_ok;
    logic                      div_start;
    logic [COORD_W-1:0]        div_dividend;
    logic [SIZE_W-1:0]         div_divisor;
    logic                      div_done;
    logic [SIZE_W-1:0]         div_rem;
    logic                      load;
    logic                      more_in_row;
    logic                      has_next;
    logic                      at_max;
    logic                      is_last;
    logic                      any_tile;
    logic signed [OUT_W-1:0]   clip_src_x;
    logic signed [OUT_W-1:0]   clip_src_y;
    logic signed [OUT_W-1:0]   clip_dst_x;
    logic signed [OUT_W-1:0]   clip_dst_y;
    logic [SIZE_W-1:0]         clip_w;
    logic [SIZE_W-1:0]         clip_h;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign size_ok    = (i_tile_width != '0) && (i_tile_height != '0);

    // the divider serves x first, then y
    assign div_start    = (accept && size_ok) || ((r_state == ST_DIVX) && div_done);
    assign div_dividend = (r_state == ST_IDLE) ? coord_mag(i_scroll_x) : coord_mag(r_scy);
    assign div_divisor  = (r_state == ST_IDLE) ? i_tile_width : r_th;

    tfb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // per-axis clipping of the tile under the cursor
    tfb_clip u_clip_x (
        .i_pos     (r_x),
        .i_pos_end (r_xe),
        .i_limit   (r_aw),
        .i_src_org (r_sl),
        .i_dst_org (r_al),
        .i_mirror  (r_mh),
        .o_src     (clip_src_x),
        .o_dst     (clip_dst_x),
        .o_len     (clip_w)
    );

    tfb_clip u_clip_y (
        .i_pos     (r_y),
        .i_pos_end (r_ye),
        .i_limit   (r_ah),
        .i_src_org (r_st),
        .i_dst_org (r_at),
        .i_mirror  (r_mv),
        .o_src     (clip_src_y),
        .o_dst     (clip_dst_y),
        .o_len     (clip_h)
    );

    // lookahead for the last word and the tile limit
    assign more_in_row = r_xe < ext_size(r_aw);
    assign has_next    = more_in_row || (r_ye < ext_size(r_ah));
    assign at_max      = (r_cnt == CNT_W'(MAX_TILES - 1));
    assign is_last     = !has_next || at_max;
    assign any_tile    = (r_fx < ext_size(r_aw)) && (r_y < ext_size(r_ah));
    assign load        = (r_state == ST_EMIT) && (!r_out_valid || i_out_ready);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && size_ok) begin
                    n_state = ST_DIVX;
                end
            end
            ST_DIVX: begin
                if (div_done) begin
                    n_state = ST_DIVY;
                end
            end
            ST_DIVY: begin
                if (div_done) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_state = any_tile ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (load && is_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // command latch
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sl      <= i_src_left;
            r_st      <= i_src_top;
            r_tw      <= i_tile_width;
            r_th      <= i_tile_height;
            r_al      <= i_area_left;
            r_at      <= i_area_top;
            r_aw      <= i_area_width;
            r_ah      <= i_area_height;
            r_scy     <= i_scroll_y;
            r_scx_neg <= i_scroll_x[COORD_W-1];
            r_mh      <= i_mirror_h;
            r_mv      <= i_mirror_v;
        end
    end

    // grid walk: wrapped start, then left to right, row by row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            if ((r_state == ST_DIVX) && div_done) begin
                r_fx <= wrap_start(r_scx_neg, div_rem, r_tw);
            end
            if ((r_state == ST_DIVY) && div_done) begin
                r_y <= wrap_start(r_scy[COORD_W-1], div_rem, r_th);
            end
            if (r_state == ST_PREP) begin
                r_x   <= r_fx;
                r_xe  <= r_fx + ext_size(r_tw);
                r_fxe <= r_fx + ext_size(r_tw);
                r_ye  <= r_y + ext_size(r_th);
                r_cnt <= '0;
            end
            if (load) begin
                r_cnt <= r_cnt + 1'b1;
                if (more_in_row) begin
                    r_x  <= r_xe;
                    r_xe <= r_xe + ext_size(r_tw);
                end else begin
                    r_x  <= r_fx;
                    r_xe <= r_fxe;
                    r_y  <= r_ye;
                    r_ye <= r_ye + ext_size(r_th);
                end
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_src_x  <= clip_src_x;
            r_src_y  <= clip_src_y;
            r_width  <= clip_w;
            r_height <= clip_h;
            r_dst_x  <= clip_dst_x;
            r_dst_y  <= clip_dst_y;
            r_flip   <= {r_mv, r_mh};
            r_last   <= is_last;
            r_trunc  <= has_next && at_max;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_blit_src_x  = r_src_x;
    assign o_blit_src_y  = r_src_y;
    assign o_blit_width  = r_width;
    assign o_blit_height = r_height;
    assign o_blit_dst_x  = r_dst_x;
    assign o_blit_dst_y  = r_dst_y;
    assign o_blit_flip   = r_flip;
    assign o_last_blit   = r_last;
    assign o_truncated   = r_trunc;

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// self-checking testbench for tiled_fill_blit_generator: directed and random fill commands
// are checked word by word against a behavioral blit predictor with random stalls on both sides
// depends on tfb_pkg and the tiled_fill_blit_generator rtl
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tfb_pkg::*;

    // one fill command as driven on the command channel
    typedef struct packed {
        logic signed [COORD_W-1:0] src_left;
        logic signed [COORD_W-1:0] src_top;
        logic [SIZE_W-1:0]         tile_w;
        logic [SIZE_W-1:0]         tile_h;
        logic signed [COORD_W-1:0] area_left;
        logic signed [COORD_W-1:0] area_top;
        logic [SIZE_W-1:0]         area_w;
        logic [SIZE_W-1:0]         area_h;
        logic signed [COORD_W-1:0] scroll_x;
        logic signed [COORD_W-1:0] scroll_y;
        logic                      mirror_h;
        logic                      mirror_v;
    } t_fill_cmd;

    // one blit word as seen on the blit channel
    typedef struct packed {
        logic [OUT_W-1:0]  src_x;
        logic [OUT_W-1:0]  src_y;
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
        logic [OUT_W-1:0]  dst_x;
        logic [OUT_W-1:0]  dst_y;
        logic [FLIP_W-1:0] flip;
        logic              last_blit;
        logic              truncated;
    } t_blit;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_ready = 1'b0;
    t_fill_cmd cmd_hold = '0;

    // raw bit patterns, compared without sign extension
    logic                      o_in_ready;
    logic                      o_out_valid;
    logic [OUT_W-1:0]          o_blit_src_x;
    logic [OUT_W-1:0]          o_blit_src_y;
    logic [SIZE_W-1:0]         o_blit_width;
    logic [SIZE_W-1:0]         o_blit_height;
    logic [OUT_W-1:0]          o_blit_dst_x;
    logic [OUT_W-1:0]          o_blit_dst_y;
    logic [FLIP_W-1:0]         o_blit_flip;
    logic                      o_last_blit;
    logic                      o_truncated;

    t_fill_cmd fill_cmd_q[$];
    t_blit     blit_expect_q[$];
    logic      cmd_taken = 1'b0;
    int        cmds_taken = 0;
    int        n_errors = 0;
    int        send_gap_pct;
    int        recv_stall_pct;

    tiled_fill_blit_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_src_left    (cmd_hold.src_left),
        .i_src_top     (cmd_hold.src_top),
        .i_tile_width  (cmd_hold.tile_w),
        .i_tile_height (cmd_hold.tile_h),
        .i_area_left   (cmd_hold.area_left),
        .i_area_top    (cmd_hold.area_top),
        .i_area_width  (cmd_hold.area_w),
        .i_area_height (cmd_hold.area_h),
        .i_scroll_x    (cmd_hold.scroll_x),
        .i_scroll_y    (cmd_hold.scroll_y),
        .i_mirror_h    (cmd_hold.mirror_h),
        .i_mirror_v    (cmd_hold.mirror_v),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_blit_src_x  (o_blit_src_x),
        .o_blit_src_y  (o_blit_src_y),
        .o_blit_width  (o_blit_width),
        .o_blit_height (o_blit_height),
        .o_blit_dst_x  (o_blit_dst_x),
        .o_blit_dst_y  (o_blit_dst_y),
        .o_blit_flip   (o_blit_flip),
        .o_last_blit   (o_last_blit),
        .o_truncated   (o_truncated)
    );

    // first grid position in (-size, 0], congruent to the offset modulo size
    function automatic longint grid_origin(input longint off, input longint size);
        longint m;
        m = off % size;
        if (m < 0) begin
            m += size;
        end
        return (m == 0) ? 0 : m - size;
    endfunction

    // walk the tile grid of one command and queue the blit words it must produce
    task automatic predict_blits(input t_fill_cmd c);
        longint sl, st, tw, th, al, at, aw, ah;
        longint x0, y0, x, y, ox, oy, cw, ch, dx, dy, sx, sy;
        int     n;
        bit     cut;
        bit     have_prev;
        t_blit  b;
        t_blit  prev;
        sl = longint'($signed(c.src_left));
        st = longint'($signed(c.src_top));
        al = longint'($signed(c.area_left));
        at = longint'($signed(c.area_top));
        tw = longint'(c.tile_w);
        th = longint'(c.tile_h);
        aw = longint'(c.area_w);
        ah = longint'(c.area_h);
        n = 0;
        cut = 1'b0;
        have_prev = 1'b0;
        prev = '0;
        // a zero tile size covers nothing
        if (tw == 0 || th == 0) begin
            return;
        end
        x0 = grid_origin(longint'($signed(c.scroll_x)), tw);
        y0 = grid_origin(longint'($signed(c.scroll_y)), th);
        for (y = y0; y < ah && !cut; y += th) begin
            for (x = x0; x < aw; x += tw) begin
                if (n >= MAX_TILES) begin
                    cut = 1'b1;
                    break;
                end
                // clip the tile against the area
                ox = (x < 0) ? -x : 0;
                oy = (y < 0) ? -y : 0;
                dx = x + ox;
                dy = y + oy;
                cw = tw - ox;
                ch = th - oy;
                if (dx + cw > aw) begin
                    cw = aw - dx;
                end
                if (dy + ch > ah) begin
                    ch = ah - dy;
                end
                // mirrored parts come from the opposite side of the tile
                sx = c.mirror_h ? sl + tw - ox - cw : sl + ox;
                sy = c.mirror_v ? st + th - oy - ch : st + oy;
                b.src_x     = OUT_W'(sx);
                b.src_y     = OUT_W'(sy);
                b.width     = SIZE_W'(cw);
                b.height    = SIZE_W'(ch);
                b.dst_x     = OUT_W'(al + dx);
                b.dst_y     = OUT_W'(at + dy);
                b.flip      = {c.mirror_v, c.mirror_h};
                b.last_blit = 1'b0;
                b.truncated = 1'b0;
                if (have_prev) begin
                    blit_expect_q.push_back(prev);
                end
                prev = b;
                have_prev = 1'b1;
                n++;
            end
        end
        // the final word carries the end and truncation marks
        if (have_prev) begin
            prev.last_blit = 1'b1;
            prev.truncated = cut;
            blit_expect_q.push_back(prev);
        end
    endtask

    function automatic t_fill_cmd fill_cmd(
        input int sl, input int st, input int tw, input int th,
        input int al, input int at, input int aw, input int ah,
        input int scx, input int scy, input bit mh, input bit mv
    );
        t_fill_cmd c;
        c.src_left  = COORD_W'(sl);
        c.src_top   = COORD_W'(st);
        c.tile_w    = SIZE_W'(tw);
        c.tile_h    = SIZE_W'(th);
        c.area_left = COORD_W'(al);
        c.area_top  = COORD_W'(at);
        c.area_w    = SIZE_W'(aw);
        c.area_h    = SIZE_W'(ah);
        c.scroll_x  = COORD_W'(scx);
        c.scroll_y  = COORD_W'(scy);
        c.mirror_h  = mh;
        c.mirror_v  = mv;
        return c;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            n_errors++;
        end
    endfunction

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // idle mix: sender light and receiver heavy, then swapped, then none
    always_comb begin
        if (cmds_taken < 75) begin
            send_gap_pct   = 10;
            recv_stall_pct = 51;
        end else if (cmds_taken < 150) begin
            send_gap_pct   = 51;
            recv_stall_pct = 10;
        end else begin
            send_gap_pct   = 0;
            recv_stall_pct = 0;
        end
    end

    // command driver, changes inputs on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid  <= 1'b0;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
            if (in_valid && !cmd_taken) begin
                // hold the word until it is taken
            end else if (fill_cmd_q.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
                cmd_hold <= fill_cmd_q.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor: predict on command accept, check each blit word taken
    always @(posedge i_clk) begin
        t_blit exp_b;
        if (!i_rst_n) begin
            cmd_taken <= 1'b0;
        end else begin
            cmd_taken <= in_valid && o_in_ready;
            if (in_valid && o_in_ready) begin
                predict_blits(cmd_hold);
                cmds_taken++;
            end
            if (o_out_valid && out_ready) begin
                if (blit_expect_q.size() == 0) begin
                    $error("blit word with none expected");
                    n_errors++;
                end else begin
                    exp_b = blit_expect_q.pop_front();
                    check_field("blit_src_x", exp_b.src_x, o_blit_src_x);
                    check_field("blit_src_y", exp_b.src_y, o_blit_src_y);
                    check_field("blit_width", exp_b.width, o_blit_width);
                    check_field("blit_height", exp_b.height, o_blit_height);
                    check_field("blit_dst_x", exp_b.dst_x, o_blit_dst_x);
                    check_field("blit_dst_y", exp_b.dst_y, o_blit_dst_y);
                    check_field("blit_flip", exp_b.flip, o_blit_flip);
                    check_field("last_blit", exp_b.last_blit, o_last_blit);
                    check_field("truncated", exp_b.truncated, o_truncated);
                end
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        t_fill_cmd c;
        int        kind;
        // zero tile sizes and empty areas
        fill_cmd_q.push_back(fill_cmd(5, 6, 0, 4, 0, 0, 20, 20, 0, 0, 0, 0));
        fill_cmd_q.push_back(fill_cmd(5, 6, 4, 0, 0, 0, 20, 20, 0, 0, 1, 1));
        fill_cmd_q.push_back(fill_cmd(5, 6, 4, 4, 10, 10, 0, 20, 1, 1, 0, 0));
        fill_cmd_q.push_back(fill_cmd(5, 6, 4, 4, 10, 10, 20, 0, 1, 1, 1, 0));
        // exactly the tile limit, then one column and one row over it
        fill_cmd_q.push_back(fill_cmd(0, 0, 1, 1, 0, 0, 8, 8, 0, 0, 0, 0));
        fill_cmd_q.push_back(fill_cmd(0, 0, 1, 1, 0, 0, 9, 8, 0, 0, 0, 1));
        fill_cmd_q.push_back(fill_cmd(0, 0, 1, 1, 0, 0, 8, 9, 0, 0, 1, 0));
        // field extremes
        fill_cmd_q.push_back(fill_cmd(32767, 32767, 32767, 32767, 32767, 32767,
                                      32767, 32767, 32767, 32767, 1, 1));
        fill_cmd_q.push_back(fill_cmd(-32768, -32768, 32767, 32767, -32768, -32768,
                                      1, 1, -32768, -32768, 1, 1));
        fill_cmd_q.push_back(fill_cmd(-32768, 32767, 1, 32767, 32767, -32768,
                                      32767, 32767, 32767, -32768, 0, 1));
        fill_cmd_q.push_back(fill_cmd(32767, -32768, 3, 3, -32768, 32767,
                                      24, 24, -32768, 32767, 1, 0));
        // scroll a multiple of the tile, positive and negative
        fill_cmd_q.push_back(fill_cmd(100, 200, 8, 6, 50, 60, 30, 20, 16, -12, 0, 0));
        // each mirror setting on a clipped grid
        fill_cmd_q.push_back(fill_cmd(40, 30, 10, 7, -5, 9, 25, 20, 3, -4, 0, 0));
        fill_cmd_q.push_back(fill_cmd(40, 30, 10, 7, -5, 9, 25, 20, 3, -4, 1, 0));
        fill_cmd_q.push_back(fill_cmd(40, 30, 10, 7, -5, 9, 25, 20, 3, -4, 0, 1));
        fill_cmd_q.push_back(fill_cmd(40, 30, 10, 7, -5, 9, 25, 20, 3, -4, 1, 1));
        // tile bigger than the area, and a huge area truncated mid-row
        fill_cmd_q.push_back(fill_cmd(-7, 12, 500, 300, 3, 4, 120, 90, 77, 1000, 1, 0));
        fill_cmd_q.push_back(fill_cmd(0, 0, 2, 3, 0, 0, 32767, 32767, -1, 5, 0, 1));

        // random commands, mostly grids of a few to a hundred tiles
        repeat (192) begin
            kind = $urandom_range(99);
            c = t_fill_cmd'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
            if (kind < 55) begin
                c.tile_w = SIZE_W'($urandom_range(1, 40));
                c.tile_h = SIZE_W'($urandom_range(1, 40));
                c.area_w = SIZE_W'($urandom_range(0, 9 * c.tile_w));
                c.area_h = SIZE_W'($urandom_range(0, 9 * c.tile_h));
            end else if (kind < 70) begin
                c.tile_w = SIZE_W'($urandom_range(1, 4));
                c.tile_h = SIZE_W'($urandom_range(1, 4));
            end else if (kind < 90) begin
                // all fields fully random
            end else begin
                case ($urandom_range(3))
                    0: c.tile_w = '0;
                    1: c.tile_h = '0;
                    2: c.area_w = '0;
                    default: c.area_h = '0;
                endcase
            end
            fill_cmd_q.push_back(c);
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (fill_cmd_q.size() > 0 || in_valid || blit_expect_q.size() > 0) begin
            @(posedge i_clk);
        end
        // let a late or spurious word show up
        repeat (120) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("tiled_fill_blit_generator: match");
        end else begin
            $display("tiled_fill_blit_generator: mismatch");
        end
        $finish;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("tiled_fill_blit_generator: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
hdl/tfb_pkg.sv
hdl/tfb_div.sv
hdl/tfb_clip.sv
hdl/tiled_fill_blit_generator.sv
verif/tb_top.sv
